[rtl/complement_strand_matcher_assert.svh]
// Assertion macros for the complement strand matcher checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef COMPLEMENT_STRAND_MATCHER_ASSERT_SVH
`define COMPLEMENT_STRAND_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define CSM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("complement_strand_matcher: assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define CSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("complement_strand_matcher: assertion failed");

`endif

[rtl/csm_pkg.sv]
// Shared types, constants and helper functions of the complement strand matcher.
// Used by every module of the block; depends on nothing.
package csm_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int MAX_STRAND  = 1048576;

	localparam int CODE_W = 2;
	localparam int WIN_W  = CODE_W * MAX_PATTERN;
	localparam int CNT_W  = $clog2(MAX_STRAND) + 1;
	localparam int PAT_W  = 32;
	localparam int LEN_W  = 5;
	localparam int POS_W  = 20;
	localparam int CHAR_W = 8;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int SH_W   = $clog2(MAX_PATTERN) + 1;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_PATTERN_BASES  = 2'd0;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
	localparam logic [1:0] REG_START_POSITION = 2'd2;

	localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = LEN_W'(1);

	// ASCII characters of the four bases.
	localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

	localparam logic [CODE_W-1:0] CODE_A = 2'd0;
	localparam logic [CODE_W-1:0] CODE_C = 2'd1;
	localparam logic [CODE_W-1:0] CODE_G = 2'd2;
	localparam logic [CODE_W-1:0] CODE_T = 2'd3;

	typedef struct packed {
		logic [PAT_W-1:0] pattern_bases;
		logic [LEN_W-1:0] pattern_length;
		logic [POS_W-1:0] start_position;
	} cfg_t;

	typedef struct packed {
		logic             match_found;
		logic [POS_W-1:0] match_position;
		logic             invalid_base;
		logic             strand_too_short;
		logic [WIN_W-1:0] window_next;
		logic [CNT_W-1:0] count_next;
	} step_t;

	// Decoded base: valid flag in the top bit, code below it.
	function automatic logic [CODE_W:0] base_code(input logic [CHAR_W-1:0] ch);
		logic [CODE_W:0] res;
		unique case (ch)
			CHAR_A:  res = {1'b1, CODE_A};
			CHAR_C:  res = {1'b1, CODE_C};
			CHAR_G:  res = {1'b1, CODE_G};
			CHAR_T:  res = {1'b1, CODE_T};
			default: res = {1'b0, CODE_A};
		endcase
		return res;
	endfunction

endpackage

[rtl/csm_cfg_regs.sv]
// Configuration register file of the complement strand matcher, APB-style port.
// Depends on csm_pkg.
module csm_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [csm_pkg::ADDR_W-1:0] paddr,
	input  logic [csm_pkg::DATA_W-1:0] pwdata,
	output logic [csm_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output csm_pkg::cfg_t              cfg
);
	import csm_pkg::*;

	logic [PAT_W-1:0] pattern_bases_q;
	logic [LEN_W-1:0] pattern_length_q;
	logic [POS_W-1:0] start_position_q;
	logic             wr_en;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bases_q  <= '0;
			pattern_length_q <= PATTERN_LENGTH_RESET;
			start_position_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PATTERN_BASES:  pattern_bases_q  <= pwdata[PAT_W-1:0];
				REG_PATTERN_LENGTH: pattern_length_q <= pwdata[LEN_W-1:0];
				REG_START_POSITION: start_position_q <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PATTERN_BASES:  prdata = DATA_W'(pattern_bases_q);
			REG_PATTERN_LENGTH: prdata = DATA_W'(pattern_length_q);
			REG_START_POSITION: prdata = DATA_W'(start_position_q);
			default:            prdata = '0;
		endcase
	end

	assign cfg.pattern_bases  = pattern_bases_q;
	assign cfg.pattern_length = pattern_length_q;
	assign cfg.start_position = start_position_q;

endmodule

[rtl/csm_step.sv]
// Combinational step of the matcher: decodes one base, shifts it into the
// window and compares the window with the complemented pattern. Depends on csm_pkg.
module csm_step (
	input  csm_pkg::cfg_t              cfg,
	input  logic [csm_pkg::CHAR_W-1:0] base_char,
	input  logic                       last_base,
	input  logic [csm_pkg::WIN_W-1:0]  window,
	input  logic [csm_pkg::CNT_W-1:0]  count,
	input  logic                       error_seen,
	output csm_pkg::step_t             res
);
	import csm_pkg::*;

	logic [LEN_W-1:0]  len;
	logic [CODE_W:0]   dec;
	logic              in_range;
	logic              at_start;
	logic              err_next;
	logic [WIN_W-1:0]  win_next;
	logic [CNT_W-1:0]  cnt_next;
	logic [CNT_W-1:0]  first;
	logic [SH_W-1:0]   shift;
	logic [WIN_W-1:0]  have;
	logic [WIN_W-1:0]  pat_ext;
	logic [MAX_PATTERN-1:0] base_ok;
	logic              long_enough;
	logic              hit;

	always_comb begin
		if (cfg.pattern_length == '0) begin
			len = LEN_W'(1);
		end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
			len = LEN_W'(MAX_PATTERN);
		end else begin
			len = cfg.pattern_length;
		end
	end

	assign dec      = base_code(base_char);
	assign in_range = count < CNT_W'(MAX_STRAND);
	assign at_start = count >= CNT_W'(cfg.start_position);

	// Bases past the overflow limit leave window, count and error untouched.
	assign err_next = error_seen | (in_range & ~dec[CODE_W] & at_start);
	assign win_next = in_range ? {dec[CODE_W-1:0], window[WIN_W-1:CODE_W]} : window;
	assign cnt_next = in_range ? count + CNT_W'(1) : count;

	// Newest len bases sit at the top of the window; bring them down to base 0.
	assign shift = SH_W'(MAX_PATTERN) - SH_W'(len);
	assign have  = win_next >> {shift, 1'b0};

	assign pat_ext = WIN_W'(cfg.pattern_bases);

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			base_ok[i] = (have[CODE_W*i +: CODE_W] == ~pat_ext[CODE_W*i +: CODE_W]) ||
				(i >= int'(len));
		end
	end

	assign long_enough = cnt_next >= CNT_W'(len);
	assign first       = cnt_next - CNT_W'(len);
	assign hit = in_range & long_enough & ~err_next & (&base_ok) &
		(first >= CNT_W'(cfg.start_position));

	assign res.match_found      = hit;
	assign res.match_position   = hit ? first[POS_W-1:0] : '0;
	assign res.invalid_base     = err_next;
	assign res.strand_too_short = last_base & (cnt_next < CNT_W'(len));
	assign res.window_next      = win_next;
	assign res.count_next       = cnt_next;

endmodule

[rtl/complement_strand_matcher.sv]
// Top level of the complement strand matcher: input register, strand state,
// result register. Depends on csm_pkg, csm_cfg_regs and csm_step.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------------
//   input    | in_valid / in_stall     | base_char, last_base
//   result   | out_valid / out_stall   | match_found, match_position, invalid_base,
//            |                         | strand_too_short
//   config   | psel, penable, pwrite   | paddr, pwdata, prdata (pready tied high)
//
// One base per cycle while out_stall does not hold the result register. Each base is
// captured in the input register, then passes the window compare into the result
// register. The strand state is updated as a base leaves the input register.
// Reset clears the strand state and both valid flags; configuration returns to
// its reset values. A held out_stall fills the result register, then the input
// register, then raises in_stall.
module complement_strand_matcher (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [csm_pkg::ADDR_W-1:0] paddr,
	input  logic [csm_pkg::DATA_W-1:0] pwdata,
	output logic [csm_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [csm_pkg::CHAR_W-1:0] base_char,
	input  logic                       last_base,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       match_found,
	output logic [csm_pkg::POS_W-1:0]  match_position,
	output logic                       invalid_base,
	output logic                       strand_too_short
);
	import csm_pkg::*;

	cfg_t              cfg;
	step_t             step;
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              valid_s2;
	logic              match_s2;
	logic [POS_W-1:0]  pos_s2;
	logic              invalid_s2;
	logic              short_s2;
	logic [WIN_W-1:0]  window_q;
	logic [CNT_W-1:0]  count_q;
	logic              error_q;
	logic              advance;
	logic              accept;

	csm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	csm_step u_step (
		.cfg        (cfg),
		.base_char  (char_s1),
		.last_base  (last_s1),
		.window     (window_q),
		.count      (count_q),
		.error_seen (error_q),
		.res        (step)
	);

	// A base moves on whenever the result register is empty or being drained.
	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			window_q <= '0;
			count_q  <= '0;
			error_q  <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (~out_stall) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				if (last_s1) begin
					window_q <= '0;
					count_q  <= '0;
					error_q  <= 1'b0;
				end else begin
					window_q <= step.window_next;
					count_q  <= step.count_next;
					error_q  <= step.invalid_base;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= base_char;
			last_s1 <= last_base;
		end
		if (advance) begin
			match_s2   <= step.match_found;
			pos_s2     <= step.match_position;
			invalid_s2 <= step.invalid_base;
			short_s2   <= step.strand_too_short;
		end
	end

	assign out_valid        = valid_s2;
	assign match_found      = match_s2;
	assign match_position   = pos_s2;
	assign invalid_base     = invalid_s2;
	assign strand_too_short = short_s2;

endmodule

[rtl/csm_checker.sv]
// Port-level checker for the complement strand matcher, bound to the top level.
// Depends on csm_pkg and complement_strand_matcher_assert.svh.
`include "complement_strand_matcher_assert.svh"

module csm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      match_found,
	input logic [csm_pkg::POS_W-1:0] match_position,
	input logic                      invalid_base,
	input logic                      strand_too_short
);
	import csm_pkg::*;

	// Without a match the reported position is zero.
	`CSM_ASSERT_SAME(a_pos_zero, out_valid && !match_found, match_position == '0)
	// A raised error suppresses matches for the rest of the strand.
	`CSM_ASSERT_SAME(a_err_no_match, out_valid && invalid_base, !match_found)
	// A strand shorter than the pattern cannot end in a match.
	`CSM_ASSERT_SAME(a_short_no_match, out_valid && strand_too_short, !match_found)
	// A stalled result stays offered.
	`CSM_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)

endmodule

bind complement_strand_matcher csm_checker u_csm_checker (.*);
